// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level RTL file of the clock and reset control block.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, held off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hdl/crcr_pkg.sv =====
// Package of the clock and reset control register block: register map,
// reset values, write masks and the structs passed between modules. No dependencies.
`default_nettype none

package crcr_pkg;

   localparam int REG_COUNT = 10;
   localparam int IDX_W     = $clog2(REG_COUNT);
   localparam int OFF_W     = 12;
   localparam int DATA_W    = 32;
   localparam int REG_W     = 4;
   localparam int USB_MAX   = 3;

   // Defaults of the top level parameters.
   localparam int DEF_USB_RESET_LINES  = 3;
   localparam int DEF_USB_CLOCK_OFFSET = 260;
   localparam int DEF_WINDOW_BYTES     = 4096;

   // Access kinds on the request channel.
   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   // Register indexes, in decode priority order.
   localparam logic [IDX_W-1:0] IX_EMMC_RST  = IDX_W'(0);
   localparam logic [IDX_W-1:0] IX_BUS_RST   = IDX_W'(1);
   localparam logic [IDX_W-1:0] IX_SDIO0_RST = IDX_W'(2);
   localparam logic [IDX_W-1:0] IX_SDIO1_RST = IDX_W'(3);
   localparam logic [IDX_W-1:0] IX_USB_RST   = IDX_W'(4);
   localparam logic [IDX_W-1:0] IX_BUS_CLK   = IDX_W'(5);
   localparam logic [IDX_W-1:0] IX_USB_CLK   = IDX_W'(6);
   localparam logic [IDX_W-1:0] IX_EMMC_CLK  = IDX_W'(7);
   localparam logic [IDX_W-1:0] IX_SDIO0_CLK = IDX_W'(8);
   localparam logic [IDX_W-1:0] IX_SDIO1_CLK = IDX_W'(9);

   // Byte offsets; the USB clock entry is replaced by the module parameter.
   localparam logic [OFF_W-1:0] REG_OFFSET [REG_COUNT] = '{
      12'h000, 12'h008, 12'h00c, 12'h010, 12'h014,
      12'h100, OFF_W'(DEF_USB_CLOCK_OFFSET), 12'h108, 12'h10c, 12'h110
   };

   localparam logic [REG_W-1:0] REG_RESET [REG_COUNT] = '{
      4'h3, 4'h3, 4'h1, 4'h1, 4'h1, 4'h1, 4'hf, 4'h1, 4'h1, 4'h1
   };

   localparam logic [REG_W-1:0] REG_MASK [REG_COUNT] = '{
      4'h3, 4'h3, 4'h1, 4'h1, 4'h7, 4'h1, 4'hf, 4'h1, 4'h1, 4'h1
   };

   localparam logic [REG_W-1:0] EMMC_RST_MASK = 4'h3;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] index;
   } decode_type;

   typedef struct packed {
      logic [USB_MAX-1:0] usb_rst;
      logic [2:0]         stor_rst;
      logic [7:0]         clk_en;
   } levels_type;

endpackage

`default_nettype wire

// ===== hdl/crcr_channels.sv =====
// Handshake channels of the clock and reset control block: bus access in,
// access result out. Depends on crcr_pkg.
`default_nettype none

interface crcr_req_if;
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic [crcr_pkg::OFF_W-1:0]  byte_offset;
   logic [crcr_pkg::DATA_W-1:0] write_data;

   modport source (output valid, output action, output byte_offset, output write_data,
                   input ready);
   modport sink   (input valid, input action, input byte_offset, input write_data,
                   output ready);
endinterface

interface crcr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [crcr_pkg::DATA_W-1:0]  read_data;
   logic                        access_error;
   logic [crcr_pkg::USB_MAX-1:0] usb_reset_lines;
   logic [2:0]                  storage_reset_lines;
   logic [7:0]                  clock_enable_lines;

   modport source (output valid, output read_data, output access_error,
                   output usb_reset_lines, output storage_reset_lines,
                   output clock_enable_lines, input ready);
   modport sink   (input valid, input read_data, input access_error,
                   input usb_reset_lines, input storage_reset_lines,
                   input clock_enable_lines, output ready);
endinterface

`default_nettype wire

// ===== hdl/crcr_decode.sv =====
// Address decoder of the clock and reset control block: byte offset to
// register index with first-match priority. Depends on crcr_pkg.
`default_nettype none

module crcr_decode #(
   parameter int USB_CLOCK_OFFSET = crcr_pkg::DEF_USB_CLOCK_OFFSET,
   parameter int WINDOW_BYTES     = crcr_pkg::DEF_WINDOW_BYTES
) (
   input  wire logic [crcr_pkg::OFF_W-1:0] byte_offset,
   output crcr_pkg::decode_type            dec
);

   logic in_window;

   assign in_window = 32'(byte_offset) < 32'(WINDOW_BYTES);

   // Scan from the last entry down so the earliest match wins.
   always_comb begin
      logic [crcr_pkg::OFF_W-1:0] off;
      dec = '0;
      for (int i = crcr_pkg::REG_COUNT - 1; i >= 0; i--) begin
         off = (crcr_pkg::IDX_W'(i) == crcr_pkg::IX_USB_CLK)
               ? crcr_pkg::OFF_W'(USB_CLOCK_OFFSET) : crcr_pkg::REG_OFFSET[i];
         if (in_window && byte_offset == off) begin
            dec.hit   = 1'b1;
            dec.index = crcr_pkg::IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/crcr_regfile.sv =====
// Register store of the clock and reset control block: masked writes, read
// mux and the derived reset and clock enable levels. Depends on crcr_pkg.
`default_nettype none

module crcr_regfile #(
   parameter int USB_RESET_LINES = crcr_pkg::DEF_USB_RESET_LINES
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        write_en,
   input  wire logic [crcr_pkg::IDX_W-1:0]  index,
   input  wire logic [crcr_pkg::DATA_W-1:0] write_data,
   output logic      [crcr_pkg::REG_W-1:0]  read_value,
   output crcr_pkg::levels_type             levels_next,
   output crcr_pkg::levels_type             levels_now
);

   logic [crcr_pkg::REG_W-1:0] store_ff [crcr_pkg::REG_COUNT];
   logic [crcr_pkg::REG_W-1:0] store_in [crcr_pkg::REG_COUNT];

   function automatic crcr_pkg::levels_type levels_of(
      input logic [crcr_pkg::REG_W-1:0] s [crcr_pkg::REG_COUNT]);
      crcr_pkg::levels_type lv;
      lv = '0;
      for (int i = 0; i < crcr_pkg::USB_MAX; i++) begin
         if (i < USB_RESET_LINES) lv.usb_rst[i] = ~s[crcr_pkg::IX_USB_RST][i];
      end
      lv.stor_rst[0] = (s[crcr_pkg::IX_EMMC_RST] & crcr_pkg::EMMC_RST_MASK)
                       != crcr_pkg::EMMC_RST_MASK;
      lv.stor_rst[1] = ~s[crcr_pkg::IX_SDIO0_RST][0];
      lv.stor_rst[2] = ~s[crcr_pkg::IX_SDIO1_RST][0];
      lv.clk_en = {s[crcr_pkg::IX_SDIO1_CLK][0], s[crcr_pkg::IX_SDIO0_CLK][0],
                   s[crcr_pkg::IX_EMMC_CLK][0], s[crcr_pkg::IX_USB_CLK],
                   s[crcr_pkg::IX_BUS_CLK][0]};
      return lv;
   endfunction

   // Merge only the bits under the register's write mask.
   always_comb begin
      for (int i = 0; i < crcr_pkg::REG_COUNT; i++) begin
         store_in[i] = store_ff[i];
         if (write_en && index == crcr_pkg::IDX_W'(i)) begin
            store_in[i] = (store_ff[i] & ~crcr_pkg::REG_MASK[i])
                        | (write_data[crcr_pkg::REG_W-1:0] & crcr_pkg::REG_MASK[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < crcr_pkg::REG_COUNT; i++) begin
         if (reset) store_ff[i] <= crcr_pkg::REG_RESET[i];
         else       store_ff[i] <= store_in[i];
      end
   end

   always_comb begin
      read_value = '0;
      for (int i = 0; i < crcr_pkg::REG_COUNT; i++) begin
         if (index == crcr_pkg::IDX_W'(i)) read_value = store_ff[i];
      end
   end

   assign levels_next = levels_of(store_in);
   assign levels_now  = levels_of(store_ff);

endmodule

`default_nettype wire

// ===== hdl/clock_reset_control_registers.sv =====
// Top level of the clock and reset control register block: input stage,
// decoder, register store and result register. Depends on crcr_pkg,
// crcr_channels, crcr_decode, crcr_regfile and assert_macros.svh.
//
//   channel   dir   payload                                         accepted when
//   req_bus   in    action, byte_offset, write_data                 valid & ready
//   rsp_bus   out   read_data, access_error, usb_reset_lines,      valid & ready
//                   storage_reset_lines, clock_enable_lines
//
// From acceptance, each item is held in the input register, then passes through
// decode and masked write into the result register. One item per cycle is
// sustained while rsp_bus.ready is high; the input stage and the result register
// each hold one item, so input is taken while a result waits.
// Synchronous reset loads every register with its reset value and empties both stages.
// A stalled result holds; the input stage then holds, and req_bus.ready drops
// once both stages are full.
`default_nettype none
`include "assert_macros.svh"

module clock_reset_control_registers #(
   parameter int USB_RESET_LINES  = crcr_pkg::DEF_USB_RESET_LINES,
   parameter int USB_CLOCK_OFFSET = crcr_pkg::DEF_USB_CLOCK_OFFSET,
   parameter int WINDOW_BYTES     = crcr_pkg::DEF_WINDOW_BYTES
) (
   input wire logic  clock,
   input wire logic  reset,
   crcr_req_if.sink   req_bus,
   crcr_rsp_if.source rsp_bus
);

   // Input stage.
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_action_ff;
   logic [crcr_pkg::OFF_W-1:0]  s1_offset_ff;
   logic [crcr_pkg::DATA_W-1:0] s1_data_ff;

   // Result register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [crcr_pkg::DATA_W-1:0] rsp_rdata_ff, rsp_rdata_in;
   logic                        rsp_error_ff;
   crcr_pkg::levels_type        rsp_levels_ff;

   logic                        s1_advance;
   logic                        req_take;
   crcr_pkg::decode_type        dec;
   logic [crcr_pkg::REG_W-1:0]  read_value;
   crcr_pkg::levels_type        levels_next;
   crcr_pkg::levels_type        levels_now;

   // Advance the input stage whenever the result register is empty or drains.
   assign s1_advance    = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign s1_valid_in   = req_take || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in  = s1_advance || (rsp_valid_ff && !rsp_bus.ready);

   crcr_decode #(
      .USB_CLOCK_OFFSET (USB_CLOCK_OFFSET),
      .WINDOW_BYTES     (WINDOW_BYTES)
   ) u_decode (
      .byte_offset (s1_offset_ff),
      .dec         (dec)
   );

   // Commit a write only as the item leaves the input stage, so state moves in order.
   crcr_regfile #(
      .USB_RESET_LINES (USB_RESET_LINES)
   ) u_regfile (
      .clock       (clock),
      .reset       (reset),
      .write_en    (s1_advance && (s1_action_ff == crcr_pkg::ACT_WRITE) && dec.hit),
      .index       (dec.index),
      .write_data  (s1_data_ff),
      .read_value  (read_value),
      .levels_next (levels_next),
      .levels_now  (levels_now)
   );

   // Reads of implemented registers return the stored value; everything else reads zero.
   assign rsp_rdata_in = (dec.hit && (s1_action_ff == crcr_pkg::ACT_READ))
                         ? {{(crcr_pkg::DATA_W - crcr_pkg::REG_W){1'b0}}, read_value}
                         : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         s1_action_ff <= req_bus.action;
         s1_offset_ff <= req_bus.byte_offset;
         s1_data_ff   <= req_bus.write_data;
      end
      // Levels are taken from the store as it stands after this access.
      if (s1_advance) begin
         rsp_rdata_ff  <= rsp_rdata_in;
         rsp_error_ff  <= !dec.hit;
         rsp_levels_ff <= levels_next;
      end
   end

   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.read_data           = rsp_rdata_ff;
   assign rsp_bus.access_error        = rsp_error_ff;
   assign rsp_bus.usb_reset_lines     = rsp_levels_ff.usb_rst;
   assign rsp_bus.storage_reset_lines = rsp_levels_ff.stor_rst;
   assign rsp_bus.clock_enable_lines  = rsp_levels_ff.clk_en;

   // A blocked item stays in the input stage.
   `ASSERT_CLK(a_s1_hold, clock, reset, s1_valid_ff && !s1_advance |=> s1_valid_ff, "input item lost while stalled")
   // With no access committing, the shown levels match the stored state.
   `ASSERT_CLK(a_levels_track, clock, reset, rsp_valid_ff && !s1_advance |-> rsp_levels_ff == levels_now, "result levels out of step with store")
   // Unaligned offsets never decode.
   `ASSERT_CLK(a_unaligned_miss, clock, reset, s1_valid_ff && s1_offset_ff[1:0] != 2'b00 |-> !dec.hit, "unaligned offset decoded")
   // An error result carries zero data.
   `ASSERT_CLK(a_error_zero, clock, reset, rsp_valid_ff && rsp_error_ff |-> rsp_rdata_ff == '0, "error result with nonzero data")
   // Back pressure only when the input stage is occupied.
   `ASSERT_ALWAYS(a_ready_full, clock, !req_bus.ready |-> s1_valid_ff, "ready low with empty input stage")

endmodule

`default_nettype wire
